// ===== design/ffba_pkg.sv =====
// Shared types, codes and constants of the first-fit block allocator.
package ffba_pkg;

  localparam int HDR_W = 13;
  localparam logic [HDR_W-1:0] SIZE_MASK = 13'h1FFE;
  localparam logic [11:0] HEAP_BYTES_RESET = 12'd4084;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_FREE     = 2'd1,
    ACT_COALESCE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_EVAL,
    S_A_SPLIT,
    S_F_WRITE,
    S_C_LOAD,
    S_C_HEAD,
    S_C_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] request_bytes;
    logic [9:0]  block_address;
  } req_item_t;

  typedef struct packed {
    logic       status;
    logic [9:0] payload_address;
  } rsp_item_t;

endpackage

// ===== design/ffba_hdr_ram.sv =====
// Header word store: one write port and one registered read port.
module ffba_hdr_ram
  import ffba_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [HDR_W-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [HDR_W-1:0]         rd_data
);

  logic [HDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator over an implicit header list.
//
// Usage: requests arrive as beats on the req channel (valid/ready) and each
// request gives exactly one response beat on the rsp channel (valid/ready).
// An allocate walks the block headers from word 1 at one header per cycle,
// then writes the split-off remainder when it splits a block; a free reads the
// header, writes it back and responds; a coalesce loads each next header and
// merges it into the current block when both are free. The single read port
// of the header memory sets the pace of each walk. One request is in flight
// at a time.
// The heap_bytes register is written through cfg_we/cfg_wdata. Reset and
// every register write start a clearing pass that sweeps all HEAP_WORDS
// header words and lays out one free block at word 1 followed by the end
// marker; req_ready stays low during the sweep.
// The response sits in an output register, so a new request is taken while
// the previous response waits; if the receiver stalls, the finished result
// of that next request waits in the done state until the register drains.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int HEAP_WORDS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int AW = $clog2(HEAP_WORDS);
  // Wide enough for a word index plus a block size in words.
  localparam int PW = ((AW > 11) ? AW : 11) + 1;
  localparam int CAP = (HEAP_WORDS * 4) & ~7;
  localparam int CAP_LIM = (CAP > 8184) ? 8184 : CAP;
  localparam logic [AW-1:0] LAST_WORD = AW'(HEAP_WORDS - 1);
  localparam logic [AW-1:0] FIRST_WORD = AW'(1);

  state_t state, state_next;

  logic [11:0]      heap_bytes;
  logic [AW-1:0]    clr_idx;
  logic [HDR_W-1:0] need;
  logic [AW-1:0]    p;
  logic [HDR_W-1:0] rem;
  logic [AW-1:0]    fh;
  logic [AW-1:0]    t;
  logic [AW-1:0]    n;
  logic [HDR_W-1:0] cur_h;
  logic             res_fail;
  logic [9:0]       res_addr;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [HDR_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [HDR_W-1:0] rd_data;

  // Heap layout derived from the size register.
  logic [12:0]   a_raw;
  logic [12:0]   a_bytes;
  logic [PW-1:0] end_w;
  logic [AW-1:0] heap_end;
  logic [12:0]   first_size;

  assign a_raw      = ({1'b0, heap_bytes} + 13'd19) & ~13'd7;
  assign a_bytes    = (a_raw > 13'(CAP_LIM)) ? 13'(CAP_LIM) : a_raw;
  assign end_w      = PW'(a_bytes[12:2]) - PW'(1);
  assign heap_end   = end_w[AW-1:0];
  assign first_size = a_bytes - 13'd8;

  // Request decode at acceptance.
  logic          req_fire;
  logic [12:0]   req_need;
  logic [PW-1:0] free_hw;
  logic          free_ok;

  assign req_fire = req_valid && req_ready;
  assign req_need = ({1'b0, req.request_bytes} + 13'd11) & ~13'd7;
  assign free_hw  = PW'(req.block_address) - PW'(1);
  assign free_ok  = (req.block_address != 10'd0) && (free_hw < PW'(HEAP_WORDS));

  // Allocation walk decisions on the header just read.
  logic [HDR_W-1:0] sz;
  logic             hdr_free;
  logic [PW-1:0]    nxt_w;
  logic [PW-1:0]    q_w;
  logic             a_exact, a_split, a_fail;

  assign sz       = rd_data & SIZE_MASK;
  assign hdr_free = !rd_data[0];
  assign nxt_w    = PW'(p) + PW'(sz[12:2]);
  assign q_w      = PW'(p) + PW'(need[12:2]);
  assign a_exact  = (sz != '0) && hdr_free && (sz == need);
  assign a_split  = (sz != '0) && hdr_free && (sz > need);
  assign a_fail   = (sz == '0) || (!a_exact && !a_split && (nxt_w >= PW'(heap_end)));

  // Coalesce decisions.
  logic [HDR_W-1:0] cur_sz;
  logic [PW-1:0]    cn_w;
  logic             c_stop;
  logic             c_end;
  logic             c_merge;
  logic [HDR_W-1:0] merged;

  assign cur_sz  = cur_h & SIZE_MASK;
  assign cn_w    = PW'(t) + PW'(cur_sz[12:2]);
  assign c_stop  = (cur_sz == '0) || (cn_w >= PW'(heap_end));
  assign c_end   = (sz == '0);
  assign c_merge = !cur_h[0] && hdr_free;
  assign merged  = cur_sz + sz;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_WORD) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) begin
          case (req.action)
            ACT_ALLOC:    state_next = S_A_EVAL;
            ACT_FREE:     state_next = free_ok ? S_F_WRITE : S_DONE;
            ACT_COALESCE: state_next = S_C_LOAD;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_A_EVAL: begin
        if (a_exact || a_fail) state_next = S_DONE;
        else if (a_split)      state_next = S_A_SPLIT;
      end
      S_A_SPLIT: state_next = S_DONE;
      S_F_WRITE: state_next = S_DONE;
      S_C_LOAD:  state_next = S_C_HEAD;
      S_C_HEAD:  state_next = c_stop ? S_DONE : S_C_NEXT;
      S_C_NEXT:  state_next = c_end ? S_DONE : S_C_HEAD;
      S_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
    if (cfg_we) state_next = S_CLEAR;
  end

  // Memory port and handshake controls.
  always_comb begin
    req_ready = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = clr_idx;
    wr_data   = '0;
    rd_addr   = FIRST_WORD;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = (clr_idx == FIRST_WORD) ? first_size : '0;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        rd_addr   = (req.action == ACT_FREE) ? free_hw[AW-1:0] : FIRST_WORD;
      end
      S_A_EVAL: begin
        rd_addr = nxt_w[AW-1:0];
        if (a_exact || a_split) begin
          wr_en   = 1'b1;
          wr_addr = p;
          wr_data = need + 13'd1;
        end
      end
      S_A_SPLIT: begin
        wr_en   = (q_w < PW'(HEAP_WORDS));
        wr_addr = q_w[AW-1:0];
        wr_data = rem;
      end
      S_F_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = fh;
        wr_data = rd_data & SIZE_MASK;
      end
      S_C_HEAD: begin
        rd_addr = cn_w[AW-1:0];
      end
      S_C_NEXT: begin
        if (!c_end && c_merge) begin
          wr_en   = 1'b1;
          wr_addr = t;
          wr_data = merged;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      heap_bytes <= HEAP_BYTES_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        heap_bytes <= cfg_wdata;
        clr_idx    <= '0;
      end else if (state == S_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        need     <= req_need;
        p        <= FIRST_WORD;
        t        <= FIRST_WORD;
        fh       <= free_hw[AW-1:0];
        res_fail <= 1'b0;
        res_addr <= '0;
      end
      S_A_EVAL: begin
        rem <= sz - need;
        if (a_fail) res_fail <= 1'b1;
        // Keep p on the block being split so the remainder lands after it.
        if (a_exact || a_split) begin
          res_addr <= 10'(PW'(p) + PW'(1));
        end else begin
          p <= nxt_w[AW-1:0];
        end
      end
      S_C_LOAD: cur_h <= rd_data;
      S_C_HEAD: n <= cn_w[AW-1:0];
      S_C_NEXT: begin
        if (c_merge) begin
          cur_h <= merged;
        end else begin
          cur_h <= rd_data;
          t     <= n;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp.status          <= res_fail;
          rsp.payload_address <= res_addr;
        end
      end
      default: begin
        res_fail <= res_fail;
      end
    endcase
  end

  ffba_hdr_ram #(
    .DEPTH(HEAP_WORDS)
  ) u_hdr_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // An accepted request always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state != S_IDLE)
    else $error("request accepted but controller stayed idle");

  // The allocation walk never reaches or passes the end marker.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_A_EVAL |-> p < heap_end)
    else $error("allocation walk beyond end marker");

  // Coalesce always looks at a header strictly after the current block.
  a_coal_fwd: assert property (@(posedge clk) disable iff (rst)
    state == S_C_NEXT |-> n > t)
    else $error("coalesce neighbor not after current block");

  // A failed allocation never reports an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_fail) |-> res_addr == '0)
    else $error("failed allocation carries an address");

endmodule
